@@ src/pqir_pkg.sv @@
// ----------------------------------------------------------------------------
// pqir_pkg: shared types and constants for the play queue
// Port widths, request and status codes, controller states and the result
// bundle that passes from the controller to the output stage.
// ----------------------------------------------------------------------------
package pqir_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 16;

    localparam int TYPE_W   = 2;
    localparam int ID_W     = 16;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int QLEN_W   = 5;

    typedef enum logic [TYPE_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_PLAY   = 2'd2
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PLAY,
        S_SHIFT,
        S_RESULT
    } t_state;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   now_playing_id;
        logic              now_playing_valid;
        logic [QLEN_W-1:0] queue_length;
    } t_result;

endpackage

@@ src/play_queue_with_indexed_removal_top.sv @@
// ----------------------------------------------------------------------------
// play_queue_with_indexed_removal_top: play queue with indexed removal
// Bounded queue of identifiers with append, remove at position and play.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_req_valid / o_req_ready with a type, an identifier
//   and a position. Each request produces exactly one result on
//   o_rsp_valid / i_rsp_ready carrying a status, the now-playing identifier
//   and flag, and the number of entries left in the queue.
//   The entries live in a circular memory with a registered read port.
//   An append is written directly into the memory. A play reads the head
//   entry through the registered read port.
//   A removal at position p of a queue of n entries copies every later entry
//   one place toward the head, one per cycle through the memory read port;
//   removing the last entry copies nothing.
//   Each result is taken into the output register from the controller's
//   result state, after any play or shift states.
//   Reset empties the queue and clears the now-playing register; no memory
//   clearing pass is needed. If the receiver stalls, one result waits in the
//   output register while the next request is still taken and worked on;
//   its result then waits inside the controller until the register frees.
// ----------------------------------------------------------------------------
module play_queue_with_indexed_removal_top
    import pqir_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  logic [TYPE_W-1:0]   i_req_type,
    input  logic [ID_W-1:0]     i_song_id,
    input  logic [POS_W-1:0]    i_item_position,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_now_playing_id,
    output logic                o_now_playing_valid,
    output logic [QLEN_W-1:0]   o_queue_length
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [ID_BITS-1:0] w_wr_data;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic [ID_BITS-1:0] w_rd_data;
    logic               w_res_valid;
    logic               w_res_ready;
    t_result            w_res;

    logic               r_out_valid;
    t_result            r_out;

    pqir_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ID_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    pqir_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_req_valid),
        .o_req_ready     (o_req_ready),
        .i_req_type      (i_req_type),
        .i_song_id       (i_song_id),
        .i_item_position (i_item_position),
        .o_res_valid     (w_res_valid),
        .i_res_ready     (w_res_ready),
        .o_res           (w_res),
        .o_wr_en         (w_wr_en),
        .o_wr_addr       (w_wr_addr),
        .o_wr_data       (w_wr_data),
        .o_rd_en         (w_rd_en),
        .o_rd_addr       (w_rd_addr),
        .i_rd_data       (w_rd_data)
    );

    assign w_res_ready = !r_out_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_rsp_valid         = r_out_valid;
    assign o_status            = r_out.status;
    assign o_now_playing_id    = r_out.now_playing_id;
    assign o_now_playing_valid = r_out.now_playing_valid;
    assign o_queue_length      = r_out.queue_length;

endmodule

@@ src/pqir_ram.sv @@
// ----------------------------------------------------------------------------
// pqir_ram: queue entry storage
// Simple dual-port memory with one write port and one read port. Read data
// is registered and appears in the cycle after the read enable.
// ----------------------------------------------------------------------------
module pqir_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/pqir_ctrl.sv @@
// ----------------------------------------------------------------------------
// pqir_ctrl: queue controller
// Keeps the head pointer, entry count and now-playing register, and runs
// each request against the circular entry memory. Removal moves the later
// entries one place toward the head, one entry per cycle.
// ----------------------------------------------------------------------------
module pqir_ctrl
    import pqir_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    input  logic [TYPE_W-1:0]              i_req_type,
    input  logic [ID_W-1:0]                i_song_id,
    input  logic [POS_W-1:0]               i_item_position,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output t_result                        o_res,
    output logic                           o_wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_wr_addr,
    output logic [ID_BITS-1:0]             o_wr_data,
    output logic                           o_rd_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_rd_addr,
    input  logic [ID_BITS-1:0]             i_rd_data
);

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [AW-1:0]      r_head, n_head;
    logic [ID_BITS-1:0] r_playing_id, n_playing_id;
    logic               r_playing_valid, n_playing_valid;
    t_req               r_req, n_req;
    logic [ID_BITS-1:0] r_song_id, n_song_id;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [AW-1:0]      r_idx, n_idx;
    t_status            r_status, n_status;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic               w_in_range;
    logic               w_no_shift;
    logic               w_more;
    logic [CNT_W-1:0]   w_idx_ext;

    function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (AW+1)'(QUEUE_DEPTH)) begin
            s = s - (AW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_full      = (r_count >= CNT_W'(QUEUE_DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_in_range  = (CMP_W'(r_pos) < CMP_W'(r_count));
    assign w_no_shift  = ((CMP_W+1)'(r_pos) + (CMP_W+1)'(1)) >= (CMP_W+1)'(r_count);
    assign w_idx_ext   = CNT_W'(r_idx);
    assign w_more      = (w_idx_ext + CNT_W'(2)) < r_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RESULT;
                case (r_req)
                    REQ_REMOVE: begin
                        if (w_in_range && !w_no_shift) begin
                            n_state = S_SHIFT;
                        end
                    end
                    REQ_PLAY: begin
                        if (!w_empty) begin
                            n_state = S_PLAY;
                        end
                    end
                    default: begin
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_PLAY: begin
                n_state = S_RESULT;
            end
            S_SHIFT: begin
                if (!w_more) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count         = r_count;
        n_head          = r_head;
        n_playing_id    = r_playing_id;
        n_playing_valid = r_playing_valid;
        n_req           = r_req;
        n_song_id       = r_song_id;
        n_pos           = r_pos;
        n_idx           = r_idx;
        n_status        = r_status;
        o_wr_en         = 1'b0;
        o_wr_addr       = addr_of(r_head, r_idx);
        o_wr_data       = i_rd_data;
        o_rd_en         = 1'b0;
        o_rd_addr       = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req     = t_req'(i_req_type);
                    n_song_id = ID_BITS'(i_song_id);
                    n_pos     = i_item_position;
                end
            end
            S_DECODE: begin
                n_status = STAT_RANGE;
                case (r_req)
                    REQ_APPEND: begin
                        if (w_full) begin
                            n_status = STAT_FULL;
                        end else begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = addr_of(r_head, AW'(r_count));
                            o_wr_data = r_song_id;
                            n_count   = r_count + CNT_W'(1);
                            n_status  = STAT_OK;
                        end
                    end
                    REQ_REMOVE: begin
                        if (w_in_range) begin
                            n_status = STAT_OK;
                            n_idx    = AW'(r_pos);
                            if (w_no_shift) begin
                                n_count = r_count - CNT_W'(1);
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = addr_of(r_head, AW'(CNT_W'(r_pos) + CNT_W'(1)));
                            end
                        end
                    end
                    REQ_PLAY: begin
                        if (!w_empty) begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = r_head;
                            n_status  = STAT_OK;
                        end
                    end
                    default: begin
                        n_status = STAT_RANGE;
                    end
                endcase
            end
            S_PLAY: begin
                n_playing_id    = i_rd_data;
                n_playing_valid = 1'b1;
                n_head          = addr_of(r_head, AW'(1));
                n_count         = r_count - CNT_W'(1);
            end
            S_SHIFT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = addr_of(r_head, r_idx);
                o_wr_data = i_rd_data;
                n_idx     = r_idx + AW'(1);
                if (w_more) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = addr_of(r_head, AW'(w_idx_ext + CNT_W'(2)));
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_RESULT: begin
                n_status = r_status;
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_count         <= '0;
            r_head          <= '0;
            r_playing_id    <= '0;
            r_playing_valid <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_count         <= n_count;
            r_head          <= n_head;
            r_playing_id    <= n_playing_id;
            r_playing_valid <= n_playing_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_song_id <= n_song_id;
        r_pos     <= n_pos;
        r_idx     <= n_idx;
        r_status  <= n_status;
    end

    assign o_res_valid               = (r_state == S_RESULT);
    assign o_res.status              = r_status;
    assign o_res.now_playing_id      = ID_W'(r_playing_id);
    assign o_res.now_playing_valid   = r_playing_valid;
    assign o_res.queue_length        = QLEN_W'(r_count);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> ($stable(r_count) && $stable(r_head)))
        else $error("Queue state changed while the controller was idle.");

    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing_valid |=> r_playing_valid)
        else $error("Now-playing valid flag dropped without reset.");

    a_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en && o_rd_en) |-> (o_wr_addr != o_rd_addr))
        else $error("Read and write hit the same entry in one cycle.");
`endif

endmodule

@@ test/play_queue_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// play_queue_checker: request and response checker for the play queue
// Watches both handshake channels. Every accepted request is run through a
// behavioral copy of the queue to produce the expected response, and every
// accepted response is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module play_queue_checker
    import pqir_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_ready,
    input  logic [TYPE_W-1:0]   i_req_type,
    input  logic [ID_W-1:0]     i_song_id,
    input  logic [POS_W-1:0]    i_item_position,
    input  logic                i_rsp_valid,
    input  logic                i_rsp_ready,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [ID_W-1:0]     i_now_playing_id,
    input  logic                i_now_playing_valid,
    input  logic [QLEN_W-1:0]   i_queue_length,
    output int                  o_fail_count,
    output int                  o_pending
);

    logic [ID_W-1:0] waiting_ids[$];
    logic [ID_W-1:0] playing_id;
    logic            playing_valid;
    t_result         pending_results[$];
    t_result         oldest;
    int              errors;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        errors       = 0;
    end

    task automatic predict_command(
        input logic [TYPE_W-1:0] kind,
        input logic [ID_W-1:0]   id,
        input logic [POS_W-1:0]  pos
    );
        t_result want;
        want.status = STAT_RANGE;
        case (kind)
            REQ_APPEND: begin
                if (waiting_ids.size() >= QUEUE_DEPTH_DEF) begin
                    want.status = STAT_FULL;
                end else begin
                    waiting_ids.push_back(id);
                    want.status = STAT_OK;
                end
            end
            REQ_REMOVE: begin
                if (int'(pos) < waiting_ids.size()) begin
                    waiting_ids.delete(int'(pos));
                    want.status = STAT_OK;
                end
            end
            REQ_PLAY: begin
                if (waiting_ids.size() > 0) begin
                    playing_id    = waiting_ids.pop_front();
                    playing_valid = 1'b1;
                    want.status   = STAT_OK;
                end
            end
            default: begin
            end
        endcase
        want.now_playing_id    = playing_id;
        want.now_playing_valid = playing_valid;
        want.queue_length      = QLEN_W'(waiting_ids.size());
        pending_results.push_back(want);
    endtask

    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, label, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            waiting_ids.delete();
            pending_results.delete();
            playing_id    = '0;
            playing_valid = 1'b0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: response with no request outstanding, actual status %0d",
                             $time, i_status);
                    errors++;
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("status", oldest.status, i_status);
                    check_field("now_playing_id", oldest.now_playing_id, i_now_playing_id);
                    check_field("now_playing_valid", oldest.now_playing_valid,
                                i_now_playing_valid);
                    check_field("queue_length", oldest.queue_length, i_queue_length);
                end
            end
            if (i_req_valid && i_req_ready) begin
                predict_command(i_req_type, i_song_id, i_item_position);
            end
        end
        o_fail_count <= errors;
        o_pending    <= pending_results.size();
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the play queue with indexed removal
// Drives a directed opening and then biased random request streams with
// bursty gaps and response backpressure, including one long receiver hold.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
    import pqir_pkg::*;

    localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int RANDOM_ITEMS    = 1125;
    localparam int TAIL_ITEMS      = 150;
    localparam int SEGMENT_ITEMS   = 60;
    localparam int PRESSURE_AFTER  = 300;
    localparam int PRESSURE_CYCLES = 200;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 40;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_req_valid;
    logic                o_req_ready;
    logic [TYPE_W-1:0]   i_req_type;
    logic [ID_W-1:0]     i_song_id;
    logic [POS_W-1:0]    i_item_position;
    logic                o_rsp_valid;
    logic                i_rsp_ready;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_now_playing_id;
    logic                o_now_playing_valid;
    logic [QLEN_W-1:0]   o_queue_length;

    int fail_count;
    int pending;
    int rsp_count;
    int stall_cycles;
    bit tail_phase;
    bit pressure_done;

    play_queue_with_indexed_removal_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req_valid         (i_req_valid),
        .o_req_ready         (o_req_ready),
        .i_req_type          (i_req_type),
        .i_song_id           (i_song_id),
        .i_item_position     (i_item_position),
        .o_rsp_valid         (o_rsp_valid),
        .i_rsp_ready         (i_rsp_ready),
        .o_status            (o_status),
        .o_now_playing_id    (o_now_playing_id),
        .o_now_playing_valid (o_now_playing_valid),
        .o_queue_length      (o_queue_length)
    );

    play_queue_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req_valid         (i_req_valid),
        .i_req_ready         (o_req_ready),
        .i_req_type          (i_req_type),
        .i_song_id           (i_song_id),
        .i_item_position     (i_item_position),
        .i_rsp_valid         (o_rsp_valid),
        .i_rsp_ready         (i_rsp_ready),
        .i_status            (o_status),
        .i_now_playing_id    (o_now_playing_id),
        .i_now_playing_valid (o_now_playing_valid),
        .i_queue_length      (o_queue_length),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic send_request(
        input logic [TYPE_W-1:0] kind,
        input logic [ID_W-1:0]   id,
        input logic [POS_W-1:0]  pos
    );
        i_req_valid     <= 1'b1;
        i_req_type      <= kind;
        i_song_id       <= id;
        i_item_position <= pos;
        do @(posedge i_clk); while (!o_req_ready);
    endtask

    task automatic pause_requests(input int cycles);
        i_req_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    initial begin
        int                i;
        int                bias;
        int                gap_pct;
        int                roll;
        logic [TYPE_W-1:0] kind;
        logic [POS_W-1:0]  pos;

        tail_phase      = 1'b0;
        i_rst_n         <= 1'b0;
        i_req_valid     <= 1'b0;
        i_req_type      <= REQ_APPEND;
        i_song_id       <= '0;
        i_item_position <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty queue: play, removals and an unknown command are all rejected.
        send_request(REQ_PLAY, 16'h1234, 8'd0);
        send_request(REQ_REMOVE, 16'h0000, 8'd0);
        send_request(REQ_REMOVE, 16'hFFFF, 8'd255);
        send_request(REQ_UNKNOWN, 16'hA5A5, 8'd3);
        for (i = 0; i < QUEUE_DEPTH_DEF; i++) begin
            send_request(REQ_APPEND,
                         (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF
                                  : ID_W'($urandom_range(0, 65535)),
                         POS_W'($urandom_range(0, 255)));
        end
        send_request(REQ_APPEND, 16'h5A5A, 8'd0);
        send_request(REQ_REMOVE, 16'h0000, 8'd16);
        send_request(REQ_REMOVE, 16'h0000, 8'd15);
        send_request(REQ_REMOVE, 16'h0000, 8'd0);
        send_request(REQ_REMOVE, 16'h0000, 8'd5);
        send_request(REQ_PLAY, 16'h0000, 8'd0);

        bias    = 0;
        gap_pct = 0;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % SEGMENT_ITEMS == 0) begin
                bias = $urandom_range(0, 2);
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 30;
                endcase
            end
            if (i >= RANDOM_ITEMS - TAIL_ITEMS) begin
                tail_phase = 1'b1;
            end
            if (!tail_phase && $urandom_range(0, 99) < gap_pct) begin
                pause_requests($urandom_range(1, 14));
            end
            roll = $urandom_range(0, 99);
            if (roll >= 97) begin
                kind = REQ_UNKNOWN;
            end else if (roll < ((bias == 0) ? 65 : (bias == 1) ? 40 : 20)) begin
                kind = REQ_APPEND;
            end else if (roll < ((bias == 0) ? 80 : (bias == 1) ? 70 : 55)) begin
                kind = REQ_REMOVE;
            end else begin
                kind = REQ_PLAY;
            end
            pos = ($urandom_range(0, 9) == 0) ? POS_W'($urandom_range(0, 255))
                                              : POS_W'($urandom_range(0, 16));
            send_request(kind, ID_W'($urandom_range(0, 65535)), pos);
        end
        i_req_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        pressure_done = 1'b0;
        i_rsp_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!pressure_done && rsp_count >= PRESSURE_AFTER) begin
                // A long hold fills the block so that it stops taking requests.
                pressure_done = 1'b1;
                i_rsp_ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge i_clk);
            end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
                i_rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                i_rsp_ready <= 1'b1;
                if (tail_phase) begin
                    @(posedge i_clk);
                end else begin
                    repeat (($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 30))
                        @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        rsp_count    = 0;
        stall_cycles = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_rsp_valid && i_rsp_ready) begin
                rsp_count <= rsp_count + 1;
            end
            if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

endmodule
